// ===== sv/kcbp_pkg.sv =====
// shared types and constants of the keyed command block packer
package kcbp_pkg;

    localparam int ADDR_W   = 16;
    localparam int SHARED_W = 17;
    localparam int NEED_W   = 10;
    localparam int KEY_W    = 64;
    localparam int WORD_W   = 32;

    localparam logic [1:0] OP_ALLOC = 2'd0;
    localparam logic [1:0] OP_WRITE = 2'd1;
    localparam logic [1:0] OP_CLOSE = 2'd2;

    localparam logic [1:0] KIND_WORD = 2'd0;
    localparam logic [1:0] KIND_KEY  = 2'd1;
    localparam logic [1:0] KIND_STAT = 2'd2;

    localparam logic [1:0] WARN_NONE = 2'd0;
    localparam logic [1:0] WARN_FULL = 2'd1;
    localparam logic [1:0] WARN_LIST = 2'd2;
    localparam logic [1:0] WARN_ROOM = 2'd3;

    localparam logic [KEY_W-1:0]    NO_KEY      = 64'hFFFF_FFFF_FFFF_FFFF;
    localparam logic [KEY_W-1:0]    KEY_HI_MASK = 64'hFFFF_FFFF_FFFF_0000;
    localparam logic [SHARED_W-1:0] LIMIT_RESET = 17'd65536;

    typedef struct packed {
        logic [1:0]        op;
        logic [KEY_W-1:0]  surf_key;
        logic [NEED_W-1:0] words_needed;
        logic [WORD_W-1:0] data_word;
    } t_in_item;

    typedef struct packed {
        logic [1:0]        kind;
        logic [ADDR_W-1:0] buffer_addr;
        logic [WORD_W-1:0] buffer_word;
        logic [KEY_W-1:0]  emitted_key;
        logic              ok;
        logic [1:0]        warning;
        logic              last;
    } t_out_item;

    // all results of one input item, in output order: word, key, status
    typedef struct packed {
        logic              has_word;
        logic [ADDR_W-1:0] word_addr;
        logic [WORD_W-1:0] word_data;
        logic              has_key;
        logic [KEY_W-1:0]  key;
        logic              has_stat;
        logic              ok;
        logic [1:0]        warn;
    } t_bundle;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

endpackage

// ===== sv/keyed_command_block_packer_unit.sv =====
// top level of the keyed command block packer
//
// Packs keyed runs of command words into BLOCK_WORDS-word blocks reserved from
// a BUFFER_WORDS-word shared buffer. An input transaction is taken every cycle
// while the QUEUE_DEPTH-entry result queue has room; the front end settles all
// state for the item in that same cycle. Each item yields one to three results
// (word write, emitted key, status), delivered one per cycle by the back end
// while the output is ready, so sustained rate is one item per cycle for
// single-result items, lower where multi-result items keep the port busy.
// The surface list limit register may be written at any time the unit is idle.
module keyed_command_block_packer_unit
    import kcbp_pkg::*;
#(
    parameter int BLOCK_WORDS  = 512,
    parameter int BUFFER_WORDS = 65536,
    parameter int QUEUE_DEPTH  = 4
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  t_in_item            i_in_item,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output t_out_item           o_out_item,
    input  logic                i_cfg_we,
    input  logic [SHARED_W-1:0] i_cfg_data
);

    t_bundle bundle;
    t_bundle head;
    t_q_stat q_stat;
    logic    push;
    logic    pop;

    assign o_in_ready = !q_stat.full;
    assign push       = i_in_valid && o_in_ready;

    kcbp_front #(
        .BLOCK_WORDS  (BLOCK_WORDS),
        .BUFFER_WORDS (BUFFER_WORDS)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_item     (i_in_item),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .o_bundle   (bundle)
    );

    kcbp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_bundle (bundle),
        .i_pop    (pop),
        .o_head   (head),
        .o_stat   (q_stat)
    );

    kcbp_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_head      (head),
        .i_stat      (q_stat),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item)
    );

endmodule

// ===== sv/kcbp_front.sv =====
// front end: accepts items, updates packing state and builds result bundles
module kcbp_front
    import kcbp_pkg::*;
#(
    parameter int BLOCK_WORDS  = 512,
    parameter int BUFFER_WORDS = 65536
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  t_in_item            i_item,
    input  logic                i_cfg_we,
    input  logic [SHARED_W-1:0] i_cfg_data,
    output t_bundle             o_bundle
);

    localparam int RW = $clog2(BLOCK_WORDS + 1);
    localparam int CW = (RW > NEED_W) ? RW : NEED_W;
    localparam logic [RW-1:0] BLOCK_ROOM = RW'(BLOCK_WORDS);

    logic [SHARED_W-1:0] r_limit;
    logic [KEY_W-1:0]    r_open,   n_open;
    logic [ADDR_W-1:0]   r_pos,    n_pos;
    logic [RW-1:0]       r_room,   n_room;
    logic [SHARED_W-1:0] r_shared, n_shared;
    logic [SHARED_W-1:0] r_count,  n_count;
    t_bundle             bundle;

    always_comb begin
        logic              dropped;
        logic              do_close;
        logic              oversize;
        logic              have;
        logic              fits;
        logic [RW-1:0]     room1;
        logic [ADDR_W-1:0] pos1;
        logic [ADDR_W-1:0] pos2;
        logic [KEY_W-1:0]  open1;

        n_open   = r_open;
        n_pos    = r_pos;
        n_room   = r_room;
        n_shared = r_shared;
        n_count  = r_count;
        bundle   = '0;
        oversize = CW'(i_item.words_needed) >= CW'(BLOCK_WORDS);
        // one close at most: after it the open key is the no-run key
        do_close = (r_open != NO_KEY) &&
                   (oversize || (r_open != i_item.surf_key) ||
                    (CW'(r_room) <= CW'(i_item.words_needed)));
        dropped  = 1'b0;
        have     = 1'b1;
        fits     = ({1'b0, r_shared} + (SHARED_W+1)'(BLOCK_WORDS))
                   <= (SHARED_W+1)'(BUFFER_WORDS);
        room1    = r_room;
        pos1     = r_pos;
        pos2     = r_pos;
        open1    = r_open;

        case (i_item.op)
            OP_WRITE: begin
                if (r_room == '0) begin
                    bundle.has_stat = 1'b1;
                    bundle.warn     = WARN_ROOM;
                end else begin
                    bundle.has_word  = 1'b1;
                    bundle.word_addr = r_pos;
                    bundle.word_data = i_item.data_word;
                    n_pos  = r_pos + ADDR_W'(1);
                    n_room = r_room - RW'(1);
                end
            end
            OP_CLOSE: begin
                if (r_open != NO_KEY) begin
                    n_open = NO_KEY;
                    if (r_room == '0) begin
                        dropped = 1'b1;
                    end else begin
                        bundle.has_word  = 1'b1;
                        bundle.word_addr = r_pos;
                        n_pos  = r_pos + ADDR_W'(1);
                        n_room = r_room - RW'(1);
                    end
                end
                bundle.has_stat = 1'b1;
                bundle.ok       = !dropped;
                bundle.warn     = dropped ? WARN_ROOM : WARN_NONE;
            end
            OP_ALLOC: begin
                if (do_close) begin
                    open1 = NO_KEY;
                    if (r_room == '0) begin
                        dropped = 1'b1;
                    end else begin
                        bundle.has_word  = 1'b1;
                        bundle.word_addr = r_pos;
                        pos1  = r_pos + ADDR_W'(1);
                        room1 = r_room - RW'(1);
                    end
                end
                n_open          = open1;
                n_pos           = pos1;
                n_room          = room1;
                pos2            = pos1;
                bundle.has_stat = 1'b1;
                if (oversize) begin
                    n_room      = '0;
                    bundle.warn = WARN_FULL;
                end else begin
                    if (CW'(room1) <= CW'(i_item.words_needed)) begin
                        if (fits) begin
                            pos2     = r_shared[ADDR_W-1:0];
                            n_pos    = pos2;
                            n_shared = r_shared + SHARED_W'(BLOCK_WORDS);
                            n_room   = BLOCK_ROOM;
                        end else begin
                            n_room      = '0;
                            have        = 1'b0;
                            bundle.warn = WARN_FULL;
                        end
                    end
                    if (have) begin
                        if (open1 == i_item.surf_key) begin
                            bundle.ok = 1'b1;
                        end else if (r_count < r_limit) begin
                            n_open         = i_item.surf_key;
                            bundle.has_key = 1'b1;
                            bundle.key     = (i_item.surf_key & KEY_HI_MASK) |
                                             {{(KEY_W-ADDR_W){1'b0}}, pos2};
                            n_count        = r_count + SHARED_W'(1);
                            bundle.ok      = 1'b1;
                        end else begin
                            bundle.warn = WARN_LIST;
                        end
                    end
                end
                if (dropped && (bundle.warn == WARN_NONE)) begin
                    bundle.warn = WARN_ROOM;
                end
            end
            default: begin
                bundle.has_stat = 1'b1;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit  <= LIMIT_RESET;
            r_open   <= NO_KEY;
            r_pos    <= '1;
            r_room   <= '0;
            r_shared <= '0;
            r_count  <= '0;
        end else begin
            if (i_cfg_we) begin
                r_limit <= i_cfg_data;
            end
            if (i_push) begin
                r_open   <= n_open;
                r_pos    <= n_pos;
                r_room   <= n_room;
                r_shared <= n_shared;
                r_count  <= n_count;
            end
        end
    end

    assign o_bundle = bundle;

    a_room_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        CW'(r_room) <= CW'(BLOCK_WORDS))
        else $error("block room above block size");

    a_shared_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (SHARED_W+1)'(r_shared) <= (SHARED_W+1)'(BUFFER_WORDS))
        else $error("shared reservation beyond buffer");

    a_count_on_push: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rst_n && !$stable(r_count) |-> $past(i_push) || !$past(i_rst_n))
        else $error("key count moved without a transaction");

endmodule

// ===== sv/kcbp_queue.sv =====
// short bundle queue between front and back
module kcbp_queue
    import kcbp_pkg::*;
#(
    parameter int DEPTH = 4
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_bundle i_bundle,
    input  logic    i_pop,
    output t_bundle o_head,
    output t_q_stat o_stat
);

    localparam int PW = $clog2(DEPTH);
    localparam int NW = $clog2(DEPTH + 1);

    t_bundle       r_mem [DEPTH];
    logic [PW-1:0] r_wr;
    logic [PW-1:0] r_rd;
    logic [NW-1:0] r_count;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_bundle;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == PW'(DEPTH - 1)) ? '0 : r_wr + PW'(1);
            end
            if (i_pop) begin
                r_rd <= (r_rd == PW'(DEPTH - 1)) ? '0 : r_rd + PW'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + NW'(1);
            end else if (i_pop && !i_push) begin
                r_count <= r_count - NW'(1);
            end
        end
    end

    assign o_head       = r_mem[r_rd];
    assign o_stat.full  = (r_count == NW'(DEPTH));
    assign o_stat.empty = (r_count == '0);

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_stat.full))
        else $error("push into full queue");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_pop && o_stat.empty))
        else $error("pop from empty queue");

endmodule

// ===== sv/kcbp_back.sv =====
// back end: walks the head bundle and delivers its results one by one
module kcbp_back
    import kcbp_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_bundle   i_head,
    input  t_q_stat   i_stat,
    output logic      o_pop,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out_item
);

    logic r_done_word;
    logic r_done_key;
    logic need_word;
    logic need_key;
    logic fire;
    t_out_item item;

    assign need_word = i_head.has_word && !r_done_word;
    assign need_key  = i_head.has_key && !r_done_key;

    always_comb begin
        item = '0;
        if (need_word) begin
            item.kind        = KIND_WORD;
            item.buffer_addr = i_head.word_addr;
            item.buffer_word = i_head.word_data;
            item.last        = !(i_head.has_key || i_head.has_stat);
        end else if (need_key) begin
            item.kind        = KIND_KEY;
            item.emitted_key = i_head.key;
            item.last        = !i_head.has_stat;
        end else begin
            item.kind    = KIND_STAT;
            item.ok      = i_head.ok;
            item.warning = i_head.warn;
            item.last    = 1'b1;
        end
    end

    assign o_out_valid = !i_stat.empty;
    assign o_out_item  = item;
    assign fire        = o_out_valid && i_out_ready;
    assign o_pop       = fire && item.last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done_word <= 1'b0;
            r_done_key  <= 1'b0;
        end else if (fire) begin
            if (item.last) begin
                r_done_word <= 1'b0;
                r_done_key  <= 1'b0;
            end else if (need_word) begin
                r_done_word <= 1'b1;
            end else begin
                r_done_key <= 1'b1;
            end
        end
    end

    a_pop_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |=> !r_done_word && !r_done_key)
        else $error("progress marks survive a finished bundle");

    a_key_after_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done_key |-> !need_word)
        else $error("key delivered ahead of its word");

endmodule
